/* rtl/bucketed_hash_join_core_macros.svh */
// assertion macros for the hash join core
`ifndef BUCKETED_HASH_JOIN_CORE_MACROS_SVH
`define BUCKETED_HASH_JOIN_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define HJ_ASSERT_IMPLY(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) else $error(msg);
`define HJ_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) else $error(msg);
`else
`define HJ_ASSERT_IMPLY(lbl, clk, rst_n, a, b, msg)
`define HJ_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg)
`endif
`endif

/* rtl/bhj_pkg.sv */
// constants and types shared by the hash join core
`default_nettype none
package bhj_pkg;
    localparam int BUCKETS      = 256;
    localparam int CAPACITY     = 1024;
    localparam int BUCKET_LIMIT = 64;
    localparam int DATA_W       = 31;
    localparam int TUPLE_W      = 2 * DATA_W;
    localparam int BKT_W        = $clog2(BUCKETS);
    localparam int ADDR_W       = $clog2(CAPACITY);
    localparam int CNT_W        = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        K_BUILD  = 2'd0,
        K_FINISH = 2'd1,
        K_PROBE  = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_MATCH    = 3'd0,
        S_NO_MATCH = 3'd1,
        S_STORED   = 3'd2,
        S_DROPPED  = 3'd3,
        S_FINISHED = 3'd4,
        S_CLEARED  = 3'd5,
        S_WRONG    = 3'd6
    } t_status;
endpackage
`default_nettype wire

/* rtl/bhj_ram.sv */
// simple dual port ram, one write and one registered read port
`default_nettype none
module bhj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/bucketed_hash_join_core.sv */
// hash join core: build, finish and probe items each run with busy high; clear and reset run a
// clearing pass over the BUCKETS (256) bucket counters, busy high throughout; probe results come
// one per cycle at most, set by the ordered store port. every other item gives one result, on the
// ports as busy falls, but a rejected item gives S_WRONG with busy low; the receiver cannot stall.
// reset is synchronous active low and returns to the build phase with an empty table.
`default_nettype none
`include "bucketed_hash_join_core_macros.svh"
module bucketed_hash_join_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [30:0] i_tuple_key,
    input  wire logic [30:0] i_tuple_value,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [30:0]      o_right_key,
    output logic [30:0]      o_left_key,
    output logic [30:0]      o_joined_value,
    output logic             o_last
);
    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_BLD, ST_FSUM_RD, ST_FSUM_WR,
        ST_SC_RAW, ST_SC_PTR, ST_SC_WR, ST_PRB_SET, ST_PRB_SCAN, ST_PRB_END
    } t_state;

    localparam int DW = bhj_pkg::DATA_W;
    localparam int BW = bhj_pkg::BKT_W;
    localparam int AW = bhj_pkg::ADDR_W;
    localparam int CW = bhj_pkg::CNT_W;
    localparam int TW = bhj_pkg::TUPLE_W;
    localparam logic [CW-1:0] CAP    = CW'(bhj_pkg::CAPACITY);
    localparam logic [CW-1:0] LIMIT  = CW'(bhj_pkg::BUCKET_LIMIT);
    localparam logic [CW-1:0] LASTB  = CW'(bhj_pkg::BUCKETS - 1);

    t_state          r_state;
    logic [CW-1:0]   r_idx, r_sum, r_stored, r_hi;
    logic            r_phase, r_clr_ack, r_dv, r_found;
    logic [DW-1:0]   r_key, r_value, r_pend_key;
    logic            r_valid, r_last;
    bhj_pkg::t_status r_status;
    logic [DW-1:0]   r_rkey, r_lkey, r_jval;

    // memory ports
    logic            raw_we, ord_we, ptr_we, sta_we;
    logic [AW-1:0]   ord_waddr;
    logic [TW-1:0]   raw_rd, ord_rd;
    logic [BW-1:0]   ptr_waddr, ptr_raddr;
    logic [CW-1:0]   ptr_wdata, ptr_rd, sta_rd;
    logic            accept;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        raw_we    = 1'b0;
        ord_we    = 1'b0;
        ptr_we    = 1'b0;
        sta_we    = 1'b0;
        ptr_waddr = r_value[BW-1:0];
        ptr_wdata = '0;
        ptr_raddr = i_tuple_value[BW-1:0];
        ord_waddr = ptr_rd[AW-1:0];
        case (r_state)
            ST_CLR: begin
                ptr_we    = 1'b1;
                ptr_waddr = r_idx[BW-1:0];
            end
            ST_BLD: begin
                if (r_stored != CAP && ptr_rd < LIMIT) begin
                    raw_we    = 1'b1;
                    ptr_we    = 1'b1;
                    ptr_wdata = ptr_rd + CW'(1);
                end
            end
            ST_FSUM_RD: ptr_raddr = r_idx[BW-1:0];
            ST_FSUM_WR: begin
                ptr_we    = 1'b1;
                sta_we    = 1'b1;
                ptr_waddr = r_idx[BW-1:0];
                ptr_wdata = r_sum;
            end
            ST_SC_PTR: ptr_raddr = raw_rd[BW-1:0];
            ST_SC_WR: begin
                ord_we    = 1'b1;
                ptr_we    = 1'b1;
                ptr_wdata = ptr_rd + CW'(1);
            end
            default: ;
        endcase
    end

    bhj_ram #(.WIDTH(TW), .DEPTH(bhj_pkg::CAPACITY)) u_raw (
        .i_clk(i_clk), .i_we(raw_we), .i_waddr(r_stored[AW-1:0]),
        .i_wdata({r_key, r_value}), .i_raddr(r_idx[AW-1:0]), .o_rdata(raw_rd)
    );
    bhj_ram #(.WIDTH(TW), .DEPTH(bhj_pkg::CAPACITY)) u_ord (
        .i_clk(i_clk), .i_we(ord_we), .i_waddr(ord_waddr),
        .i_wdata({r_key, r_value}), .i_raddr(r_idx[AW-1:0]), .o_rdata(ord_rd)
    );
    // bucket counters during build, fill pointers during scatter, bucket ends for probes
    bhj_ram #(.WIDTH(CW), .DEPTH(bhj_pkg::BUCKETS)) u_ptr (
        .i_clk(i_clk), .i_we(ptr_we), .i_waddr(ptr_waddr),
        .i_wdata(ptr_wdata), .i_raddr(ptr_raddr), .o_rdata(ptr_rd)
    );
    bhj_ram #(.WIDTH(CW), .DEPTH(bhj_pkg::BUCKETS)) u_sta (
        .i_clk(i_clk), .i_we(sta_we), .i_waddr(r_idx[BW-1:0]),
        .i_wdata(r_sum), .i_raddr(i_tuple_value[BW-1:0]), .o_rdata(sta_rd)
    );

    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        r_last  <= 1'b1;
        r_rkey  <= '0;
        r_lkey  <= '0;
        r_jval  <= '0;
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_idx     <= '0;
            r_phase   <= 1'b0;
            r_stored  <= '0;
            r_clr_ack <= 1'b0;
            r_dv      <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            case (r_state)
                ST_CLR: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx == LASTB) begin
                        r_state <= ST_IDLE;
                        if (r_clr_ack) begin
                            r_valid  <= 1'b1;
                            r_status <= bhj_pkg::S_CLEARED;
                        end
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_key   <= i_tuple_key;
                        r_value <= i_tuple_value;
                        r_idx   <= '0;
                        r_sum   <= '0;
                        case (bhj_pkg::t_kind'(i_kind))
                            bhj_pkg::K_CLEAR: begin
                                r_state   <= ST_CLR;
                                r_phase   <= 1'b0;
                                r_stored  <= '0;
                                r_clr_ack <= 1'b1;
                            end
                            bhj_pkg::K_BUILD: begin
                                if (r_phase) begin
                                    r_valid  <= 1'b1;
                                    r_status <= bhj_pkg::S_WRONG;
                                end else begin
                                    r_state <= ST_BLD;
                                end
                            end
                            bhj_pkg::K_FINISH: begin
                                if (r_phase) begin
                                    r_valid  <= 1'b1;
                                    r_status <= bhj_pkg::S_WRONG;
                                end else begin
                                    r_state <= ST_FSUM_RD;
                                end
                            end
                            default: begin
                                if (!r_phase) begin
                                    r_valid  <= 1'b1;
                                    r_status <= bhj_pkg::S_WRONG;
                                end else begin
                                    r_state <= ST_PRB_SET;
                                end
                            end
                        endcase
                    end
                end
                ST_BLD: begin
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                    if (r_stored != CAP && ptr_rd < LIMIT) begin
                        r_stored <= r_stored + CW'(1);
                        r_status <= bhj_pkg::S_STORED;
                    end else begin
                        r_status <= bhj_pkg::S_DROPPED;
                    end
                end
                ST_FSUM_RD: r_state <= ST_FSUM_WR;
                ST_FSUM_WR: begin
                    r_sum <= r_sum + ptr_rd;
                    if (r_idx == LASTB) begin
                        r_idx <= '0;
                        if (r_stored == '0) begin
                            r_valid  <= 1'b1;
                            r_status <= bhj_pkg::S_FINISHED;
                            r_phase  <= 1'b1;
                            r_state  <= ST_IDLE;
                        end else begin
                            r_state <= ST_SC_RAW;
                        end
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_FSUM_RD;
                    end
                end
                ST_SC_RAW: r_state <= ST_SC_PTR;
                ST_SC_PTR: begin
                    r_key   <= raw_rd[TW-1:DW];
                    r_value <= raw_rd[DW-1:0];
                    r_state <= ST_SC_WR;
                end
                ST_SC_WR: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx + CW'(1) == r_stored) begin
                        r_valid  <= 1'b1;
                        r_status <= bhj_pkg::S_FINISHED;
                        r_phase  <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        r_state <= ST_SC_RAW;
                    end
                end
                ST_PRB_SET: begin
                    r_idx   <= sta_rd;
                    r_hi    <= ptr_rd;
                    r_dv    <= 1'b0;
                    r_found <= 1'b0;
                    r_state <= ST_PRB_SCAN;
                end
                ST_PRB_SCAN: begin
                    // a match is held back until the next one is found, so the final one can carry last
                    if (r_dv && ord_rd[DW-1:0] == r_value) begin
                        if (r_found) begin
                            r_valid  <= 1'b1;
                            r_status <= bhj_pkg::S_MATCH;
                            r_rkey   <= r_pend_key;
                            r_lkey   <= r_key;
                            r_jval   <= r_value;
                            r_last   <= 1'b0;
                        end
                        r_pend_key <= ord_rd[TW-1:DW];
                        r_found    <= 1'b1;
                    end
                    if (r_idx < r_hi) begin
                        r_idx <= r_idx + CW'(1);
                        r_dv  <= 1'b1;
                    end else begin
                        r_dv    <= 1'b0;
                        r_state <= ST_PRB_END;
                    end
                end
                ST_PRB_END: begin
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                    if (r_found) begin
                        r_status <= bhj_pkg::S_MATCH;
                        r_rkey   <= r_pend_key;
                        r_lkey   <= r_key;
                        r_jval   <= r_value;
                    end else begin
                        r_status <= bhj_pkg::S_NO_MATCH;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_right_key    = r_rkey;
    assign o_left_key     = r_lkey;
    assign o_joined_value = r_jval;
    assign o_last         = r_last;

    `HJ_ASSERT_IMPLY(a_more_follows, i_clk, i_rst_n, o_valid && !o_last, busy, "beat without last while idle")
    `HJ_ASSERT_NEXT(a_item_answered, i_clk, i_rst_n, start && !busy, o_valid || busy, "item dropped")
    `HJ_ASSERT_IMPLY(a_store_bound, i_clk, i_rst_n, 1'b1, r_stored <= CAP, "stored count beyond capacity")
    `HJ_ASSERT_IMPLY(a_match_in_probe, i_clk, i_rst_n, o_valid && o_status == bhj_pkg::S_MATCH, r_phase, "match outside probe phase")
endmodule
`default_nettype wire
